// ===== sv/lss_pkg.sv =====
// shared types and constants for the largest subsequence select block
package lss_pkg;

   localparam int SYM_W  = 8;
   localparam int POS_W  = 6;
   localparam int LEN_W  = 20;
   localparam int KEEP_W = 7;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic REG_INPUT_LENGTH = 1'b0;
   localparam logic REG_KEEP_COUNT   = 1'b1;

   typedef struct packed {
      logic [LEN_W-1:0]  eff_length;
      logic [KEEP_W-1:0] keep_count;
   } cfg_type;

endpackage

// ===== sv/lss_stack_ram.sv =====
// single-port stack memory with registered read data
module lss_stack_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic                      we,
   input  logic [AW-1:0]             addr,
   input  logic [lss_pkg::SYM_W-1:0] wdata,
   output logic [lss_pkg::SYM_W-1:0] rdata
);
   import lss_pkg::*;

   logic [SYM_W-1:0] mem [DEPTH];
   logic [SYM_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/lss_csr.sv =====
// configuration registers behind the apb-style port
module lss_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lss_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lss_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [lss_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output lss_pkg::cfg_type            cfg
);
   import lss_pkg::*;

   logic [LEN_W-1:0]  length_ff, length_in;
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic              wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      length_in = length_ff;
      keep_in   = keep_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_INPUT_LENGTH: length_in = csr_pwdata[LEN_W-1:0];
            REG_KEEP_COUNT:   keep_in   = csr_pwdata[KEEP_W-1:0];
            default: begin
               length_in = length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         keep_ff   <= KEEP_W'(1);
      end else begin
         length_ff <= length_in;
         keep_ff   <= keep_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_INPUT_LENGTH: csr_prdata = CSR_DW'(length_ff);
         REG_KEEP_COUNT:   csr_prdata = CSR_DW'(keep_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready     = 1'b1;
   assign cfg.eff_length = (length_ff == '0) ? LEN_W'(1) : length_ff;
   assign cfg.keep_count = keep_ff;

endmodule

// ===== sv/largest_subsequence_select.sv =====
// top level: monotonic stack selecting the lexicographically largest subsequence
// each item is taken in idle, then compared; the compare state repeats for every symbol it pops off the stack
// a new item is taken only back in idle, after the stack memory read before each compare of the last one
// after the last item of a sequence each result is read from memory, then loaded into the output when it is free
// the first result follows the final compare via ST_EMIT_RD then ST_EMIT_WAIT; input stalls until the last loads
// reset is synchronous, clears depth and count and sets config to 1; stack contents stay undefined
module largest_subsequence_select #(
   parameter int MAX_KEEP = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lss_pkg::SYM_W-1:0]   req_symbol,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lss_pkg::SYM_W-1:0]   rsp_out_symbol,
   output logic [lss_pkg::POS_W-1:0]   rsp_out_position,
   output logic                        rsp_last_of_run,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lss_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [lss_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [lss_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import lss_pkg::*;

   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int DW = $clog2(MAX_KEEP + 1);
   localparam int SW = LEN_W + 2;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_CMP       = 2'd1;
   localparam logic [1:0] ST_EMIT_RD   = 2'd2;
   localparam logic [1:0] ST_EMIT_WAIT = 2'd3;

   cfg_type cfg;

   logic [1:0]       state_ff, state_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [LEN_W-1:0] seen_ff, seen_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             ram_en, ram_we;
   logic [AW-1:0]    ram_addr;
   logic [SYM_W-1:0] ram_rdata;

   logic [DW-1:0]    keep_eff;
   logic signed [SW-1:0] avail;
   logic             pop, push, seq_end, out_free, emit_last, req_take;
   logic [LEN_W-1:0] seen_next;
   logic [DW-1:0]    depth_after;

   lss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lss_stack_ram #(
      .DEPTH (MAX_KEEP),
      .AW    (AW)
   ) u_stack_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (sym_ff),
      .rdata (ram_rdata)
   );

   assign keep_eff = (cfg.keep_count > KEEP_W'(MAX_KEEP)) ? DW'(MAX_KEEP)
                                                          : DW'(cfg.keep_count);
   assign avail = $signed({2'b00, cfg.eff_length}) + $signed(SW'(depth_ff))
                - $signed({2'b00, seen_ff});

   assign pop = (depth_ff != '0) && (avail > $signed(SW'(keep_eff)))
             && (sym_ff > ram_rdata);
   assign push        = depth_ff < keep_eff;
   assign depth_after = push ? depth_ff + DW'(1) : depth_ff;
   assign seen_next   = seen_ff + LEN_W'(1);
   assign seq_end     = (seen_next >= cfg.eff_length) || (seen_next == '0);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit_last   = (DW'({1'b0, idx_ff}) + DW'(1)) == depth_ff;
   assign req_take    = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      seen_in       = seen_ff;
      idx_in        = idx_ff;
      sym_in        = sym_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = AW'(depth_ff - DW'(1));
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sym_in   = req_symbol;
               ram_en   = depth_ff != '0;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (pop) begin
               depth_in = depth_ff - DW'(1);
               ram_en   = depth_ff > DW'(1);
               ram_addr = AW'(depth_ff - DW'(2));
            end else begin
               ram_en   = push;
               ram_we   = push;
               ram_addr = AW'(depth_ff);
               depth_in = depth_after;
               if (seq_end) begin
                  seen_in = '0;
                  idx_in  = '0;
                  if (depth_after == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_EMIT_RD;
                  end
               end else begin
                  seen_in  = seen_next;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            ram_en   = 1'b1;
            ram_addr = idx_ff;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = ram_rdata;
               rsp_pos_in    = POS_W'(idx_ff);
               rsp_last_in   = emit_last;
               if (emit_last) begin
                  depth_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         seen_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         seen_ff      <= seen_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_symbol   = rsp_symbol_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_KEEP))
      else $error("stack depth beyond capacity");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_WAIT) |-> (DW'(idx_ff) < depth_ff))
      else $error("emit index past stack top");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_WAIT && out_free && emit_last)
      |=> (depth_ff == '0 && seen_ff == '0 && rsp_valid_ff && rsp_last_ff))
      else $error("run end did not clear the stack");

   a_no_push_overflow: assert property (@(posedge clock) disable iff (reset)
      (ram_en && ram_we) |-> (depth_ff < keep_eff && state_ff == ST_CMP))
      else $error("push beyond keep count");

endmodule

// ===== sim/tb_top.sv =====
// testbench for largest_subsequence_select: directed table, random sequences, stack predictor
`timescale 1ns / 100ps

module tb_top;
   import lss_pkg::*;

   localparam int MAX_KEEP    = 64;
   localparam int ITEMS       = 270;
   localparam int SETTLE      = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int PLAN_ROWS   = 37;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [POS_W-1:0] position;
      logic             last;
   } pick_type;

   typedef enum logic [1:0] {ROW_LEN, ROW_KEEP, ROW_SYM} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int unsigned  value;
      bit           typed;
      pick_type     pick;
   } plan_row_type;

   localparam pick_type NO_PICK = '0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [SYM_W-1:0]  req_symbol = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [SYM_W-1:0]  rsp_out_symbol;
   logic [POS_W-1:0]  rsp_out_position;
   logic              rsp_last_of_run;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   largest_subsequence_select #(.MAX_KEEP(MAX_KEEP)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_out_position (rsp_out_position),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stack predictor state
   logic [SYM_W-1:0]  held_syms [MAX_KEEP];
   int unsigned       held = 0;
   int unsigned       seen = 0;
   logic [LEN_W-1:0]  cfg_length = 1;
   logic [KEEP_W-1:0] cfg_keep = 1;

   pick_type     expected_picks [$];
   pick_type     fresh_picks [$];
   plan_row_type plan [PLAN_ROWS];
   int          fails = 0;
   int          items_sent = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_wanted = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_count = 0;
   int          quiet_cycles = 0;

   task automatic advance_stack(input logic [SYM_W-1:0] sym);
      int unsigned len_eff;
      int unsigned keep_eff;
      longint      room;
      fresh_picks.delete();
      len_eff  = (cfg_length == 0) ? 1 : cfg_length;
      keep_eff = (cfg_keep > MAX_KEEP) ? MAX_KEEP : cfg_keep;
      while (held > 0) begin
         room = longint'(held) + longint'(len_eff) - longint'(seen);
         if (room <= longint'(keep_eff)) break;
         if (sym > held_syms[held-1]) held--;
         else break;
      end
      if (held < keep_eff) begin
         held_syms[held] = sym;
         held++;
      end
      seen = (seen + 1) & 32'hFFFFF;
      if (seen >= len_eff || seen == 0) begin
         for (int k = 0; k < held; k++)
            fresh_picks.push_back('{held_syms[k], POS_W'(k), (k + 1 == held)});
         held = 0;
         seen = 0;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_picks.size() != 0);
   endtask

   task automatic write_reg(input logic idx, input int unsigned value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_INPUT_LENGTH) cfg_length = value[LEN_W-1:0];
      else cfg_keep = value[KEEP_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_symbol(input logic [SYM_W-1:0] s, input bit typed,
                              input pick_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= s;
      do @(posedge clock); while (req_stall);
      advance_stack(s);
      if (typed) expected_picks.push_back(want);
      else foreach (fresh_picks[i]) expected_picks.push_back(fresh_picks[i]);
      items_sent++;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         1: begin
            send_idle_pct = 87;
            stall_pct     = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct     = 87;
         end
         default: begin
            send_idle_pct = 25;
            stall_pct     = 25;
         end
      endcase
   endtask

   function automatic logic [SYM_W-1:0] random_symbol();
      if ($urandom_range(0, 2) == 0) return SYM_W'($urandom_range(0, 3));
      return SYM_W'($urandom_range(0, 255));
   endfunction

   // receiver side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_wanted && !hold_taken) begin
         hold_taken = 1'b1;
         hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_picks
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_picks.size() == 0) begin
            $error("unexpected transfer: out_symbol %0d out_position %0d last_of_run %0b",
                   rsp_out_symbol, rsp_out_position, rsp_last_of_run);
            fails++;
         end else begin
            want = expected_picks.pop_front();
            if (rsp_out_symbol !== want.symbol) begin
               $error("out_symbol: expected %0d, got %0d", want.symbol, rsp_out_symbol);
               fails++;
            end
            if (rsp_out_position !== want.position) begin
               $error("out_position: expected %0d, got %0d", want.position, rsp_out_position);
               fails++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          phase;
      int unsigned len;
      int unsigned keep;
      int unsigned len_eff;
      int          nseq;
      int          part;
      plan = '{
         '{ROW_SYM,  8'h00,   1'b1, '{8'h00, 6'd0, 1'b1}},
         '{ROW_SYM,  8'hFF,   1'b1, '{8'hFF, 6'd0, 1'b1}},
         '{ROW_LEN,  0,       1'b0, NO_PICK},
         '{ROW_KEEP, 127,     1'b0, NO_PICK},
         '{ROW_SYM,  8'h5A,   1'b1, '{8'h5A, 6'd0, 1'b1}},
         '{ROW_KEEP, 0,       1'b0, NO_PICK},
         '{ROW_SYM,  8'h33,   1'b0, NO_PICK},
         '{ROW_LEN,  5,       1'b0, NO_PICK},
         '{ROW_KEEP, 3,       1'b0, NO_PICK},
         '{ROW_SYM,  3,       1'b0, NO_PICK},
         '{ROW_SYM,  9,       1'b0, NO_PICK},
         '{ROW_SYM,  1,       1'b0, NO_PICK},
         '{ROW_SYM,  9,       1'b0, NO_PICK},
         '{ROW_SYM,  7,       1'b0, NO_PICK},
         '{ROW_LEN,  3,       1'b0, NO_PICK},
         '{ROW_KEEP, 6,       1'b0, NO_PICK},
         '{ROW_SYM,  1,       1'b0, NO_PICK},
         '{ROW_SYM,  2,       1'b0, NO_PICK},
         '{ROW_SYM,  3,       1'b0, NO_PICK},
         '{ROW_LEN,  1048575, 1'b0, NO_PICK},
         '{ROW_KEEP, 4,       1'b0, NO_PICK},
         '{ROW_SYM,  10,      1'b0, NO_PICK},
         '{ROW_SYM,  20,      1'b0, NO_PICK},
         '{ROW_SYM,  5,       1'b0, NO_PICK},
         '{ROW_SYM,  30,      1'b0, NO_PICK},
         '{ROW_SYM,  25,      1'b0, NO_PICK},
         '{ROW_LEN,  3,       1'b0, NO_PICK},
         '{ROW_SYM,  255,     1'b0, NO_PICK},
         '{ROW_LEN,  6,       1'b0, NO_PICK},
         '{ROW_KEEP, 5,       1'b0, NO_PICK},
         '{ROW_SYM,  200,     1'b0, NO_PICK},
         '{ROW_SYM,  190,     1'b0, NO_PICK},
         '{ROW_SYM,  180,     1'b0, NO_PICK},
         '{ROW_SYM,  170,     1'b0, NO_PICK},
         '{ROW_KEEP, 2,       1'b0, NO_PICK},
         '{ROW_SYM,  160,     1'b0, NO_PICK},
         '{ROW_SYM,  150,     1'b0, NO_PICK}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(3);
      foreach (plan[r]) begin
         case (plan[r].kind)
            ROW_LEN:  write_reg(REG_INPUT_LENGTH, plan[r].value);
            ROW_KEEP: write_reg(REG_KEEP_COUNT, plan[r].value);
            default:  send_symbol(SYM_W'(plan[r].value), plan[r].typed, plan[r].pick);
         endcase
      end

      phase = 0;
      while (items_sent < ITEMS || phase < 4) begin
         set_idling(phase % 4);
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(60, 80);
            default: len = $urandom_range(1, 10);
         endcase
         case ($urandom_range(0, 9))
            0:       keep = 0;
            1:       keep = $urandom_range(65, 127);
            2:       keep = 64;
            3:       keep = 1;
            default: keep = $urandom_range(1, 12);
         endcase
         if (len > 50 && $urandom_range(0, 1) == 1) keep = 64;
         nseq = (len > 50) ? 1 : $urandom_range(1, 3);
         if (phase == 2) begin
            len  = 1;
            keep = 1;
            nseq = 12;
         end
         write_reg(REG_INPUT_LENGTH, len);
         write_reg(REG_KEEP_COUNT, keep);
         if (phase == 2) hold_wanted <= 1'b1;
         len_eff = (len == 0) ? 1 : len;
         for (int s = 0; s < nseq; s++) begin
            for (int i = 0; i < len_eff; i++) begin
               if (phase == 1 && s == 0 && i == len_eff / 2) wait_drained();
               send_symbol(random_symbol(), 1'b0, NO_PICK);
            end
         end
         // unfinished sequence, carried into the next settings
         if ($urandom_range(0, 3) == 0) begin
            part = $urandom_range(0, len_eff - 1);
            for (int i = 0; i < part; i++) send_symbol(random_symbol(), 1'b0, NO_PICK);
         end
         phase++;
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (fails == 0 && expected_picks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/lss_pkg.sv
sv/lss_stack_ram.sv
sv/lss_csr.sv
sv/largest_subsequence_select.sv
sim/tb_top.sv
